// ===== rtl/mfr_pkg.sv =====
// Shared types and constants of the RGB median filter.
`default_nettype none
package mfr_pkg;

  localparam int unsigned CH_W       = 8;
  localparam int unsigned PIX_W      = 3 * CH_W;
  localparam int unsigned CNT_W      = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned KS_W       = 3;
  localparam int unsigned IW_W       = 11;
  localparam int unsigned IH_W       = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_KERNEL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

  localparam logic REQ_PIXEL = 1'b0;
  localparam logic REQ_DRAIN = 1'b1;

  typedef struct packed {
    logic             init;
    logic             acc;
    logic             close;
    logic [2:0]       bit_pos;
    logic [CNT_W-1:0] rank;
  } sel_ctl_t;

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_RUN   = 4'b0010,
    S_FLUSH = 4'b0100,
    S_DONE  = 4'b1000
  } seq_state_e;

endpackage
`default_nettype wire

// ===== rtl/mfr_in_if.sv =====
// Input pixel channel.
`default_nettype none
interface mfr_in_if
  import mfr_pkg::*;
();
  logic            valid;
  logic            ready;
  logic            req_type;
  logic [CH_W-1:0] in_red;
  logic [CH_W-1:0] in_green;
  logic [CH_W-1:0] in_blue;

  modport source(output valid, req_type, in_red, in_green, in_blue, input ready);
  modport sink(input valid, req_type, in_red, in_green, in_blue, output ready);
endinterface
`default_nettype wire

// ===== rtl/mfr_out_if.sv =====
// Output pixel channel.
`default_nettype none
interface mfr_out_if
  import mfr_pkg::*;
();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] out_red;
  logic [CH_W-1:0] out_green;
  logic [CH_W-1:0] out_blue;
  logic            frame_end;

  modport source(output valid, out_red, out_green, out_blue, frame_end, input ready);
  modport sink(input valid, out_red, out_green, out_blue, frame_end, output ready);
endinterface
`default_nettype wire

// ===== rtl/median_filter_rgb_unit.sv =====
// Streaming RGB median filter: line store, window sequencer and output register.
// Each input transfer that yields a result starts a window read of the line store: the
// (2r+1)^2 window around the output position, r = kernel radius, one position a cycle, is
// read once for each of the eight bit passes of the shared rank selector. The result waits
// in S_DONE while a stalled receiver holds the output register; no new item is taken until
// it is loaded. Items without a result leave the input side idle and ready.
// Reset: positions zero, registers at 3 / 640 / 480; the line store is not cleared.
`default_nettype none
module median_filter_rgb_unit
  import mfr_pkg::*;
#(
  parameter int unsigned MAX_KERNEL = 7,
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 2048
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  mfr_in_if.sink               pix_i,
  mfr_out_if.source            res_o,
  input  wire                  cfg_we_i,
  input  wire [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [CFG_DATA_W-1:0] cfg_data_i
);
  localparam int unsigned KCW    = $clog2(MAX_KERNEL + 1);
  localparam int unsigned RADMAX = (MAX_KERNEL - 1) / 2;
  localparam int unsigned CW     = $clog2(MAX_WIDTH + 1);
  localparam int unsigned AW     = $clog2(MAX_WIDTH);
  localparam int unsigned RW     = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned DEPTH  = MAX_KERNEL * (1 << AW);
  localparam int unsigned ADW    = $clog2(DEPTH);
  localparam int unsigned PW     = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

  logic [KS_W-1:0] ks_q;
  logic [IW_W-1:0] iw_q;
  logic [IH_W-1:0] ih_q;

  logic [KCW-1:0]   rad, span;
  logic [CW-1:0]    w_eff;
  logic [RW-1:0]    h_eff;
  logic [PW-1:0]    lag;
  logic [CNT_W-1:0] rk, k0;

  always_comb begin
    if (int'(ks_q[2:1]) > RADMAX) rad = KCW'(RADMAX);
    else rad = KCW'(ks_q[2:1]);
    if (iw_q == '0) w_eff = CW'(1);
    else if (int'(iw_q) > MAX_WIDTH) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(iw_q);
    if (ih_q == '0) h_eff = RW'(1);
    else if (int'(ih_q) > MAX_HEIGHT) h_eff = RW'(MAX_HEIGHT);
    else h_eff = RW'(ih_q);
  end

  assign span = KCW'({rad, 1'b0});
  assign lag  = PW'(rad) * PW'(w_eff) + PW'(rad);
  assign rk   = CNT_W'(rad);
  assign k0   = CNT_W'((rk * (rk + CNT_W'(1))) << 1);

  seq_state_e state_q;
  logic [CW-1:0]  in_col_q, out_col_q;
  logic [RW-1:0]  in_row_q, out_row_q;
  logic [KCW-1:0] in_slot_q, out_slot_q;
  logic [PW-1:0]  in_pos_q;
  logic [KCW-1:0] dr_q, dc_q, win_slot_q;
  logic signed [RW:0] win_row_q;
  logic signed [CW:0] win_col_q;
  logic [2:0] bit_q;
  logic act_q, vld_q;

  logic signed [RW:0] row0;
  logic signed [CW:0] col0;
  logic [KCW-1:0]     slot0;
  logic in_win, in_fire, px_ok, drain_ok, emit_go, cfg_hit, load, last;
  logic ram_we, ram_re;
  logic [PIX_W-1:0] rdata, median;
  sel_ctl_t sel_ctl;

  logic [CH_W-1:0] red_q, green_q, blue_q;
  logic            fend_q, out_valid_q;

  assign row0  = signed'({1'b0, out_row_q}) - signed'((RW + 1)'(rad));
  assign col0  = signed'({1'b0, out_col_q}) - signed'((CW + 1)'(rad));
  assign slot0 = (out_slot_q >= rad) ? out_slot_q - rad
                                     : out_slot_q + KCW'(MAX_KERNEL) - rad;

  assign in_win = (win_row_q >= 0) && (win_row_q < signed'({1'b0, h_eff}))
               && (win_col_q >= 0) && (win_col_q < signed'({1'b0, w_eff}));

  assign pix_i.ready = (state_q == S_IDLE);
  assign in_fire     = pix_i.valid && pix_i.ready;
  assign px_ok       = (pix_i.req_type == REQ_PIXEL) && (in_row_q < h_eff);
  assign drain_ok    = (pix_i.req_type == REQ_DRAIN) && (in_row_q >= h_eff);
  assign emit_go     = in_fire && ((px_ok && (in_pos_q >= lag)) || drain_ok);
  assign ram_we      = in_fire && px_ok;
  assign ram_re      = (state_q == S_RUN) && in_win;
  assign cfg_hit     = cfg_we_i && (cfg_idx_i == CFG_KERNEL || cfg_idx_i == CFG_WIDTH
                                    || cfg_idx_i == CFG_HEIGHT);
  assign load        = (state_q == S_DONE) && (!out_valid_q || res_o.ready);
  assign last        = (out_row_q == h_eff - RW'(1)) && (out_col_q == w_eff - CW'(1));

  mfr_ram #(.WIDTH(PIX_W), .DEPTH(DEPTH)) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ADW'({in_slot_q, in_col_q[AW-1:0]})),
    .wdata_i({pix_i.in_red, pix_i.in_green, pix_i.in_blue}),
    .re_i   (ram_re),
    .raddr_i(ADW'({win_slot_q, win_col_q[AW-1:0]})),
    .rdata_o(rdata)
  );

  always_comb begin
    sel_ctl.init    = emit_go;
    sel_ctl.acc     = act_q;
    sel_ctl.close   = (state_q == S_FLUSH);
    sel_ctl.bit_pos = bit_q;
    sel_ctl.rank    = k0;
  end

  mfr_select u_select (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sel_ctl),
    .elem_i  (vld_q ? rdata : '0),
    .median_o(median)
  );

  // config registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ks_q <= KS_W'(3);
      iw_q <= IW_W'(640);
      ih_q <= IH_W'(480);
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KERNEL: ks_q <= cfg_data_i[KS_W-1:0];
        CFG_WIDTH:  iw_q <= cfg_data_i[IW_W-1:0];
        CFG_HEIGHT: ih_q <= cfg_data_i[IH_W-1:0];
        default: ;
      endcase
    end
  end

  // frame positions
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      in_pos_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
    end else if (cfg_hit || (load && last)) begin
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_slot_q  <= '0;
      in_pos_q   <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_slot_q <= '0;
    end else begin
      if (ram_we) begin
        in_pos_q <= in_pos_q + PW'(1);
        if (in_col_q == w_eff - CW'(1)) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + RW'(1);
          in_slot_q <= (in_slot_q == KCW'(MAX_KERNEL - 1)) ? '0 : in_slot_q + KCW'(1);
        end else begin
          in_col_q <= in_col_q + CW'(1);
        end
      end
      if (load) begin
        if (out_col_q == w_eff - CW'(1)) begin
          out_col_q  <= '0;
          out_row_q  <= out_row_q + RW'(1);
          out_slot_q <= (out_slot_q == KCW'(MAX_KERNEL - 1)) ? '0 : out_slot_q + KCW'(1);
        end else begin
          out_col_q <= out_col_q + CW'(1);
        end
      end
    end
  end

  // window sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      bit_q      <= '0;
      dr_q       <= '0;
      dc_q       <= '0;
      win_row_q  <= '0;
      win_col_q  <= '0;
      win_slot_q <= '0;
      act_q      <= 1'b0;
      vld_q      <= 1'b0;
    end else begin
      act_q <= (state_q == S_RUN);
      vld_q <= ram_re;
      case (state_q)
        S_IDLE: begin
          if (emit_go) begin
            bit_q      <= 3'd7;
            dr_q       <= '0;
            dc_q       <= '0;
            win_row_q  <= row0;
            win_col_q  <= col0;
            win_slot_q <= slot0;
            state_q    <= S_RUN;
          end
        end
        S_RUN: begin
          if (dc_q == span) begin
            dc_q       <= '0;
            win_col_q  <= col0;
            win_row_q  <= win_row_q + signed'((RW + 1)'(1));
            win_slot_q <= (win_slot_q == KCW'(MAX_KERNEL - 1)) ? '0 : win_slot_q + KCW'(1);
            dr_q       <= dr_q + KCW'(1);
            if (dr_q == span) state_q <= S_FLUSH;
          end else begin
            dc_q      <= dc_q + KCW'(1);
            win_col_q <= win_col_q + signed'((CW + 1)'(1));
          end
        end
        S_FLUSH: begin
          if (bit_q == 3'd0) begin
            state_q <= S_DONE;
          end else begin
            bit_q      <= bit_q - 3'd1;
            dr_q       <= '0;
            dc_q       <= '0;
            win_row_q  <= row0;
            win_col_q  <= col0;
            win_slot_q <= slot0;
            state_q    <= S_RUN;
          end
        end
        S_DONE: begin
          if (load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      red_q   <= median[2*CH_W +: CH_W];
      green_q <= median[CH_W +: CH_W];
      blue_q  <= median[0 +: CH_W];
      fend_q  <= last;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.out_red   = red_q;
  assign res_o.out_green = green_q;
  assign res_o.out_blue  = blue_q;
  assign res_o.frame_end = fend_q;

`ifndef NO_ASSERTIONS
  a_wr_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> state_q == S_IDLE) else $error("line store written outside idle");
  a_out_rise: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE)) else $error("result without selection");
  a_flush_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FLUSH |-> $past(state_q == S_RUN)) else $error("flush not after run");
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_row_q <= h_eff) else $error("input row beyond frame");
`endif
endmodule
`default_nettype wire

// ===== rtl/mfr_ram.sv =====
// Generic simple dual-port RAM with registered read.
`default_nettype none
module mfr_ram #(
  parameter int unsigned WIDTH = 24,
  parameter int unsigned DEPTH = 16
) (
  input  wire                     clk_i,
  input  wire                     we_i,
  input  wire [$clog2(DEPTH)-1:0] waddr_i,
  input  wire [WIDTH-1:0]         wdata_i,
  input  wire                     re_i,
  input  wire [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]        rdata_o
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end
endmodule
`default_nettype wire

// ===== rtl/mfr_select.sv =====
// Bitwise rank selection over a streamed window, one lane per color channel.
`default_nettype none
module mfr_select
  import mfr_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire sel_ctl_t    ctl_i,
  input  wire [PIX_W-1:0]  elem_i,
  output logic [PIX_W-1:0] median_o
);
  for (genvar c = 0; c < 3; c++) begin : g_lane
    logic [CH_W-1:0]  v;
    logic [CH_W-1:0]  hmask;
    logic             hit;
    logic [CNT_W-1:0] sum;
    logic [CH_W-1:0]  pre_q;
    logic [CNT_W-1:0] rank_q;
    logic [CNT_W-1:0] cnt_q;

    assign v     = elem_i[c*CH_W +: CH_W];
    assign hmask = CH_W'({CH_W{1'b1}} << ({1'b0, ctl_i.bit_pos} + 4'd1));
    assign hit   = ctl_i.acc && ((v & hmask) == pre_q) && !v[ctl_i.bit_pos];
    assign sum   = cnt_q + CNT_W'(hit);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pre_q  <= '0;
        rank_q <= '0;
        cnt_q  <= '0;
      end else if (ctl_i.init) begin
        pre_q  <= '0;
        rank_q <= ctl_i.rank;
        cnt_q  <= '0;
      end else if (ctl_i.close) begin
        if (rank_q >= sum) begin
          pre_q[ctl_i.bit_pos] <= 1'b1;
          rank_q               <= rank_q - sum;
        end
        cnt_q <= '0;
      end else if (ctl_i.acc) begin
        cnt_q <= sum;
      end
    end

    assign median_o[c*CH_W +: CH_W] = pre_q;
  end
endmodule
`default_nettype wire
